// ===== rtl/vmac_pkg.sv =====
package vmac_pkg;

   localparam int LANES      = 8;
   localparam int NREGS      = 32;
   localparam int ELEM_W     = 16;
   localparam int ROW_W      = 5;
   localparam int LANE_W     = 3;
   localparam int ACC_W      = 48;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 56;
   localparam int APPLIED_BIT = 48;

   // request tdata field offsets, lowest bit of each field
   localparam int FUNCT_LSB   = 0;
   localparam int ELEMENT_LSB = 6;
   localparam int VS_LSB      = 10;
   localparam int VT_LSB      = 15;
   localparam int VD_LSB      = 20;
   localparam int LANE_LSB    = 25;
   localparam int WV_LSB      = 28;

   typedef enum logic [2:0] {
      REQ_EXEC    = 3'd0,
      REQ_WR_VREG = 3'd1,
      REQ_RD_VREG = 3'd2,
      REQ_WR_ACC  = 3'd3,
      REQ_RD_ACC  = 3'd4
   } req_kind_type;

   localparam logic [5:0] F_VMULF = 6'h00;
   localparam logic [5:0] F_VMUDL = 6'h04;
   localparam logic [5:0] F_VMUDM = 6'h05;
   localparam logic [5:0] F_VMUDN = 6'h06;
   localparam logic [5:0] F_VMUDH = 6'h07;
   localparam logic [5:0] F_VMACF = 6'h08;
   localparam logic [5:0] F_VMADL = 6'h0C;
   localparam logic [5:0] F_VMADM = 6'h0D;
   localparam logic [5:0] F_VMADN = 6'h0E;
   localparam logic [5:0] F_VMADH = 6'h0F;

   function automatic logic supported(input logic [5:0] f);
      return (f == F_VMULF) || (f == F_VMUDL) || (f == F_VMUDM) || (f == F_VMUDN) ||
             (f == F_VMUDH) || (f == F_VMACF) || (f == F_VMADL) || (f == F_VMADM) ||
             (f == F_VMADN) || (f == F_VMADH);
   endfunction

   function automatic logic [15:0] sra16(input logic [15:0] x);
      return {16{x[15]}};
   endfunction

   // mid and high as a signed 32-bit value, saturated to 16 bits
   function automatic logic [15:0] sclamp(input logic [15:0] md, input logic [15:0] hi);
      if (hi == sra16(md)) return md;
      return hi[15] ? 16'h8000 : 16'h7FFF;
   endfunction

   function automatic logic [15:0] uclamp(input logic [15:0] lo, input logic [15:0] md,
                                          input logic [15:0] hi);
      if (hi == sra16(hi) && sra16(md) == sra16(hi)) return lo;
      return hi[15] ? 16'h0000 : 16'hFFFF;
   endfunction

   // vt lane that feeds lane i under the element selector
   function automatic logic [2:0] bsrc(input logic [3:0] e, input logic [2:0] i);
      if (e <= 4'd1) return i;
      if (e == 4'd2) return {i[2:1], 1'b0};
      if (e == 4'd3) return {i[2:1], 1'b1};
      if (e <= 4'd7) return {i[2], e[1:0]};
      return e[2:0];
   endfunction

endpackage

// ===== rtl/vmac_ram.sv =====
module vmac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== rtl/vector_mac_unit_48bit_acc_core.sv =====
// Eight-lane 16-bit multiply / multiply-accumulate unit with 32 vector registers held in
// eight lane RAMs (two registered read ports each) and a 48-bit accumulator per lane. Each
// item goes from acceptance to result through operand read and 16x16 multiply, then
// accumulate, clamp and write-back, then the output register. One item is accepted per
// cycle when nothing stalls; an item that reads a vector register written by the item just
// ahead of it waits, since the lane RAM read port sees that write only afterwards (writes one
// step older are forwarded). Register contents read as zero until written.
module vector_mac_unit_48bit_acc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // funct, element, vs_index, vt_index, vd_index, lane, write_value, zero pad
   input  logic [vmac_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_value, op_applied, zero pad
   output logic [vmac_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import vmac_pkg::*;

   typedef struct packed {
      req_kind_type        kind;
      logic [5:0]          funct;
      logic [3:0]          element;
      logic [ROW_W-1:0]    vs;
      logic [ROW_W-1:0]    vt;
      logic [ROW_W-1:0]    vd;
      logic [LANE_W-1:0]   lane;
      logic [ACC_W-1:0]    wv;
   } item_type;

   typedef struct packed {
      logic [15:0] l;
      logic [15:0] m;
      logic [15:0] h;
      logic [15:0] r;
   } lane_res_type;

   function automatic lane_res_type lane_op(input logic [5:0] f, input logic [15:0] l,
      input logic [15:0] m, input logic [15:0] h, input logic [15:0] s,
      input logic [15:0] t, input logic [31:0] p);
      lane_res_type res;
      logic [15:0]  lo, hu, hs, hx, hi2, hi3, md, md2, sh;
      logic         c1, c2, eq;
      lo  = p[15:0];
      hu  = p[31:16];
      hs  = hu - (s[15] ? t : 16'h0) - (t[15] ? s : 16'h0);
      hx  = (f[2:0] == F_VMUDM[2:0]) ? hu - (s[15] ? t : 16'h0)
                                     : hu - (t[15] ? s : 16'h0);
      res.l = l;
      res.m = m;
      res.h = h;
      res.r = '0;
      c1 = 1'b0;
      c2 = 1'b0;
      case (f)
         F_VMULF: begin
            sh    = {lo[14:0], 1'b0};
            eq    = (s == t);
            res.l = sh + 16'h8000;
            res.m = {hs[14:0], 1'b0} + {15'b0, lo[15]} + {15'b0, lo[14]};
            res.h = (!eq && res.m[15]) ? 16'hFFFF : 16'h0000;
            res.r = (eq && res.m[15]) ? res.m - 16'd1 : res.m;
         end
         F_VMUDL: begin
            res.l = hu;
            res.m = '0;
            res.h = '0;
            res.r = hu;
         end
         F_VMADL: begin
            {c1, res.l} = {1'b0, l} + {1'b0, hu};
            {c2, res.m} = {1'b0, m} + {16'b0, c1};
            res.h = h + {15'b0, c2};
            res.r = uclamp(res.l, res.m, res.h);
         end
         F_VMUDM, F_VMUDN: begin
            res.l = lo;
            res.m = hx;
            res.h = sra16(hx);
            res.r = (f == F_VMUDM) ? hx : lo;
         end
         F_VMADM, F_VMADN: begin
            {c1, res.l} = {1'b0, l} + {1'b0, lo};
            hi2   = hx + {15'b0, c1};
            {c2, res.m} = {1'b0, m} + {1'b0, hi2};
            res.h = h + sra16(hi2) + {15'b0, c2};
            res.r = (f == F_VMADM) ? sclamp(res.m, res.h) : uclamp(res.l, res.m, res.h);
         end
         F_VMUDH: begin
            res.l = '0;
            res.m = lo;
            res.h = hs;
            res.r = sclamp(lo, hs);
         end
         F_VMADH: begin
            {c1, res.m} = {1'b0, m} + {1'b0, lo};
            res.h = h + hs + {15'b0, c1};
            res.r = sclamp(res.m, res.h);
         end
         F_VMACF: begin
            md  = {hs[14:0], lo[15]};
            {c1, res.l} = {1'b0, l} + {1'b0, lo[14:0], 1'b0};
            md2 = md + {15'b0, c1};
            hi3 = sra16(hs) + {15'b0, (md2 == 16'h0) && c1};
            {c2, res.m} = {1'b0, m} + {1'b0, md2};
            res.h = h + hi3 + {15'b0, c2};
            res.r = sclamp(res.m, res.h);
         end
         default: begin
            res.r = '0;
         end
      endcase
      return res;
   endfunction

   function automatic logic [ROW_W-1:0] row_a(input item_type it);
      return (it.kind == REQ_RD_VREG) ? it.vd : it.vs;
   endfunction

   item_type               new_item;
   item_type               s1_ff, s2_ff;
   logic                   s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic                   s1_adv, s2_adv, hazard;
   logic [ROW_W-1:0]       ra_a, ra_b;
   logic [15:0]            rd_a [LANES];
   logic [15:0]            rd_b [LANES];
   logic [NREGS-1:0][LANES-1:0] vld_ff;
   logic [LANES-1:0]       rd_vld_a_ff, rd_vld_b_ff;
   logic                   wb_valid_ff;
   logic [ROW_W-1:0]       wb_row_ff;
   logic [LANES-1:0]       wb_mask_ff;
   logic [15:0]            wb_data_ff [LANES];
   logic [15:0]            opa [LANES];
   logic [15:0]            opb [LANES];
   logic [15:0]            s2_s_ff [LANES];
   logic [15:0]            s2_t_ff [LANES];
   logic [31:0]            s2_p_ff [LANES];
   logic [15:0]            s2_rdv_ff;
   logic [ACC_W-1:0]       acc_ff [LANES];
   lane_res_type           res [LANES];
   logic                   s2_exec, s2_wr;
   logic [LANES-1:0]       wr_mask;
   logic [15:0]            wr_data [LANES];
   logic [ACC_W-1:0]       read_value;
   logic [RSP_DATA_W-1:0]  out_data_ff;

   assign new_item.kind    = req_kind_type'(req_tuser);
   assign new_item.funct   = req_tdata[FUNCT_LSB +: 6];
   assign new_item.element = req_tdata[ELEMENT_LSB +: 4];
   assign new_item.vs      = req_tdata[VS_LSB +: ROW_W];
   assign new_item.vt      = req_tdata[VT_LSB +: ROW_W];
   assign new_item.vd      = req_tdata[VD_LSB +: ROW_W];
   assign new_item.lane    = req_tdata[LANE_LSB +: LANE_W];
   assign new_item.wv      = req_tdata[WV_LSB +: ACC_W];

   // stage 2 write-back decode
   assign s2_exec = (s2_ff.kind == REQ_EXEC) && supported(s2_ff.funct);
   assign s2_wr   = s2_valid_ff && (s2_exec || s2_ff.kind == REQ_WR_VREG);

   // hold the reader while the item ahead still has to write its row
   always_comb begin
      hazard = 1'b0;
      if (s1_valid_ff && s2_wr) begin
         case (s1_ff.kind)
            REQ_EXEC:    hazard = (s2_ff.vd == s1_ff.vs) || (s2_ff.vd == s1_ff.vt);
            REQ_RD_VREG: hazard = (s2_ff.vd == s1_ff.vd);
            default:     hazard = 1'b0;
         endcase
      end
   end

   assign s2_adv     = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign s1_adv     = s1_valid_ff && !hazard && (!s2_valid_ff || s2_adv);
   assign req_tready = !s1_valid_ff || s1_adv;

   // re-read for the waiting item, else read for the incoming one
   assign ra_a = req_tready ? row_a(new_item) : row_a(s1_ff);
   assign ra_b = req_tready ? new_item.vt : s1_ff.vt;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         wr_mask[i] = s2_exec || (s2_ff.lane == LANE_W'(i));
         wr_data[i] = s2_exec ? res[i].r : s2_ff.wv[15:0];
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      vmac_ram #(.WIDTH(ELEM_W), .DEPTH(NREGS)) u_ram (
         .clock     (clock),
         .wr_en     (s2_adv && s2_wr && wr_mask[g]),
         .wr_addr   (s2_ff.vd),
         .wr_data   (wr_data[g]),
         .rd_addr_a (ra_a),
         .rd_data_a (rd_a[g]),
         .rd_addr_b (ra_b),
         .rd_data_b (rd_b[g])
      );
   end

   // operand select: last write-back forwards, unwritten lanes read zero
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (wb_valid_ff && wb_row_ff == row_a(s1_ff) && wb_mask_ff[j]) opa[j] = wb_data_ff[j];
         else opa[j] = rd_vld_a_ff[j] ? rd_a[j] : 16'h0;
         if (wb_valid_ff && wb_row_ff == s1_ff.vt && wb_mask_ff[j]) opb[j] = wb_data_ff[j];
         else opb[j] = rd_vld_b_ff[j] ? rd_b[j] : 16'h0;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         res[i] = lane_op(s2_ff.funct, acc_ff[i][15:0], acc_ff[i][31:16], acc_ff[i][47:32],
                          s2_s_ff[i], s2_t_ff[i], s2_p_ff[i]);
      end
   end

   always_comb begin
      case (s2_ff.kind)
         REQ_RD_VREG: read_value = {32'h0, s2_rdv_ff};
         REQ_RD_ACC:  read_value = acc_ff[s2_ff.lane];
         default:     read_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
         vld_ff       <= '0;
         for (int i = 0; i < LANES; i++) acc_ff[i] <= '0;
      end else begin
         if (req_tready) s1_valid_ff <= req_tvalid;
         if (s1_adv) s2_valid_ff <= 1'b1;
         else if (s2_adv) s2_valid_ff <= 1'b0;
         if (s2_adv) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         wb_valid_ff <= s2_adv && s2_wr;
         if (s2_adv && s2_wr) vld_ff[s2_ff.vd] <= vld_ff[s2_ff.vd] | wr_mask;
         if (s2_adv && s2_exec) begin
            for (int i = 0; i < LANES; i++) acc_ff[i] <= {res[i].h, res[i].m, res[i].l};
         end
         if (s2_adv && s2_ff.kind == REQ_WR_ACC) acc_ff[s2_ff.lane] <= s2_ff.wv;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) s1_ff <= new_item;
      rd_vld_a_ff <= vld_ff[ra_a];
      rd_vld_b_ff <= vld_ff[ra_b];
      wb_row_ff   <= s2_ff.vd;
      wb_mask_ff  <= wr_mask;
      for (int i = 0; i < LANES; i++) wb_data_ff[i] <= wr_data[i];
      if (s1_adv) begin
         s2_ff     <= s1_ff;
         s2_rdv_ff <= opa[s1_ff.lane];
         for (int i = 0; i < LANES; i++) begin
            s2_s_ff[i] <= opa[i];
            s2_t_ff[i] <= opb[bsrc(s1_ff.element, LANE_W'(i))];
            s2_p_ff[i] <= {16'h0, opa[i]} * {16'h0, opb[bsrc(s1_ff.element, LANE_W'(i))]};
         end
      end
      if (s2_adv) out_data_ff <= {7'b0, s2_exec, read_value};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/vmac_checker.sv =====
module vmac_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vmac_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import vmac_pkg::*;

   logic [1:0] pend_ff;
   logic       in_acc, out_acc;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + {1'b0, in_acc} - {1'b0, out_acc};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("result item without an accepted request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd3 |-> !in_acc || out_acc)
      else $error("more than three items in flight");

   a_exec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[APPLIED_BIT] |-> rsp_tdata[ACC_W-1:0] == '0)
      else $error("applied execute item carries read data");

endmodule

bind vector_mac_unit_48bit_acc_core vmac_checker u_vmac_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import vmac_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [2:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   typedef struct packed {
      logic [47:0] read_value;
      logic        op_applied;
   } vmac_result_type;

   logic [15:0]     model_vreg [NREGS][LANES];
   logic [15:0]     model_lo [LANES];
   logic [15:0]     model_md [LANES];
   logic [15:0]     model_hi [LANES];
   vmac_result_type pending_results [$];
   int              fail_count;
   int              rsp_wait;

   vector_mac_unit_48bit_acc_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [15:0] sign_fill(input logic [15:0] x);
      return x[15] ? 16'hFFFF : 16'h0000;
   endfunction

   function automatic logic [15:0] sat_signed(input logic [15:0] md, input logic [15:0] hi);
      logic signed [32:0] v;
      v = $signed({hi[15], hi, md});
      if (v > 33'sd32767) return 16'h7FFF;
      if (v < -33'sd32768) return 16'h8000;
      return md;
   endfunction

   function automatic logic [15:0] sat_unsigned(input logic [15:0] lo, input logic [15:0] md,
                                                input logic [15:0] hi);
      if (hi == sign_fill(hi) && sign_fill(md) == sign_fill(hi)) return lo;
      return hi[15] ? 16'h0000 : 16'hFFFF;
   endfunction

   function automatic logic [15:0] lane_mac(input logic [5:0] f, input int i,
                                            input logic [15:0] s, input logic [15:0] t);
      logic [31:0] pu, ps;
      logic [16:0] sum;
      logic [15:0] lo, hi, md, ov, c, p, sh, neg, eq;
      pu = {16'h0, s} * {16'h0, t};
      ps = $signed({{16{s[15]}}, s}) * $signed({{16{t[15]}}, t});
      case (f)
         F_VMULF: begin
            p = pu[15:0];
            sh = p << 1;
            hi = ps[31:16];
            model_lo[i] = sh + 16'h8000;
            model_md[i] = (hi << 1) + {15'h0, p[15]} + {15'h0, sh[15]};
            neg = sign_fill(model_md[i]);
            eq = (s == t) ? 16'hFFFF : 16'h0000;
            model_hi[i] = ~eq & neg;
            return model_md[i] + (eq & neg);
         end
         F_VMUDL, F_VMADL: begin
            lo = pu[31:16];
            if (f == F_VMUDL) begin
               model_lo[i] = lo;
               model_md[i] = '0;
               model_hi[i] = '0;
               return lo;
            end
            sum = model_lo[i] + lo;
            model_lo[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            c = 16'h0 - ov;
            sum = model_md[i] + c;
            model_md[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            model_hi[i] = model_hi[i] - ov;
            return sat_unsigned(model_lo[i], model_md[i], model_hi[i]);
         end
         F_VMUDM, F_VMUDN, F_VMADM, F_VMADN: begin
            lo = pu[15:0];
            hi = pu[31:16];
            if (f[2:0] == 3'd5) hi = hi - (sign_fill(s) & t);
            else hi = hi - (sign_fill(t) & s);
            if (!f[3]) begin
               model_lo[i] = lo;
               model_md[i] = hi;
               model_hi[i] = sign_fill(hi);
               return (f == F_VMUDM) ? hi : lo;
            end
            sum = model_lo[i] + lo;
            model_lo[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            hi = hi - ov;
            sum = model_md[i] + hi;
            model_md[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            model_hi[i] = model_hi[i] + sign_fill(hi) - ov;
            if (f == F_VMADM) return sat_signed(model_md[i], model_hi[i]);
            return sat_unsigned(model_lo[i], model_md[i], model_hi[i]);
         end
         F_VMUDH, F_VMADH: begin
            lo = pu[15:0];
            hi = ps[31:16];
            if (f == F_VMUDH) begin
               model_lo[i] = '0;
               model_md[i] = lo;
               model_hi[i] = hi;
               return sat_signed(lo, hi);
            end
            sum = model_md[i] + lo;
            model_md[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            model_hi[i] = model_hi[i] + (hi - ov);
            return sat_signed(model_md[i], model_hi[i]);
         end
         F_VMACF: begin
            lo = pu[15:0];
            hi = ps[31:16];
            md = (hi << 1) | {15'h0, lo[15]};
            hi = sign_fill(hi);
            lo = lo << 1;
            sum = model_lo[i] + lo;
            model_lo[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            md = md - ov;
            c = (md == 16'h0) ? ov : 16'h0;
            hi = hi - c;
            sum = model_md[i] + md;
            model_md[i] = sum[15:0];
            ov = sum[16] ? 16'hFFFF : 16'h0;
            model_hi[i] = model_hi[i] + hi - ov;
            return sat_signed(model_md[i], model_hi[i]);
         end
         default: return '0;
      endcase
   endfunction

   function automatic bit funct_ok(input logic [5:0] f);
      return f == F_VMULF || (f >= F_VMUDL && f <= F_VMACF) || (f >= F_VMADL && f <= F_VMADH);
   endfunction

   // compute the result of one item and advance the model state
   function automatic vmac_result_type predict_request(input logic [2:0] kind,
         input logic [5:0] f, input logic [3:0] e, input logic [4:0] vs, input logic [4:0] vt,
         input logic [4:0] vd, input logic [2:0] ln, input logic [47:0] wv);
      vmac_result_type r;
      logic [15:0] s [LANES];
      logic [15:0] t [LANES];
      logic [15:0] d [LANES];
      int src;
      r = '0;
      case (kind)
         REQ_EXEC: if (funct_ok(f)) begin
            for (int i = 0; i < LANES; i++) begin
               if (e <= 1) src = i;
               else if (e == 2) src = i & 6;
               else if (e == 3) src = (i & 6) | 1;
               else if (e <= 7) src = (i < 4) ? e - 4 : e;
               else src = e - 8;
               s[i] = model_vreg[vs][i];
               t[i] = model_vreg[vt][src];
            end
            for (int i = 0; i < LANES; i++) d[i] = lane_mac(f, i, s[i], t[i]);
            for (int i = 0; i < LANES; i++) model_vreg[vd][i] = d[i];
            r.op_applied = 1'b1;
         end
         REQ_WR_VREG: model_vreg[vd][ln] = wv[15:0];
         REQ_RD_VREG: r.read_value = {32'h0, model_vreg[vd][ln]};
         REQ_WR_ACC: {model_hi[ln], model_md[ln], model_lo[ln]} = wv;
         REQ_RD_ACC: r.read_value = {model_hi[ln], model_md[ln], model_lo[ln]};
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic send_request(input logic [2:0] kind, input logic [5:0] f,
         input logic [3:0] e, input logic [4:0] vs, input logic [4:0] vt, input logic [4:0] vd,
         input logic [2:0] ln, input logic [47:0] wv);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'h0, wv, ln, vd, vt, vs, e, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_request(kind, f, e, vs, vt, vd, ln, wv));
   endtask

   task automatic send_random_op(input bit small_regs);
      logic [4:0] vs, vt, vd;
      logic [5:0] f;
      vs = small_regs ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      vt = small_regs ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      vd = small_regs ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
         0: f = 6'($urandom_range(0, 63));
         default: begin
            f = 6'($urandom_range(0, 9));
            f = (f == 0) ? F_VMULF : (f <= 5) ? 6'(F_VMUDL + f - 1) : 6'(F_VMADL + f - 6);
         end
      endcase
      send_request(REQ_EXEC, f, 4'($urandom_range(0, 15)), vs, vt, vd, 3'd0,
                   48'({$urandom, $urandom}));
   endtask

   function automatic logic [47:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 48'h0;
         1: return 48'hFFFF_FFFF_FFFF;
         2: return 48'h0000_0000_8000;
         3: return 48'h0000_0000_7FFF;
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   // drop valid and hold until every expected result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // load every lane of registers 0..3 and all accumulators, with corner values
   task automatic test_load_and_read();
      for (int r = 0; r < 4; r++)
         for (int l = 0; l < LANES; l++)
            send_request(REQ_WR_VREG, '0, '0, '0, '0, 5'(r), 3'(l), pick_value());
      for (int l = 0; l < LANES; l++)
         send_request(REQ_WR_ACC, '0, '0, '0, '0, '0, 3'(l), pick_value());
      for (int l = 0; l < LANES; l++) begin
         send_request(REQ_RD_VREG, '0, '0, '0, '0, 5'd1, 3'(l), '0);
         send_request(REQ_RD_ACC, '0, '0, '0, '0, '0, 3'(l), '0);
      end
   endtask

   // every funct, the minus-one-squared case, all element selectors, bad kinds
   task automatic test_directed_ops();
      logic [5:0] f;
      for (int l = 0; l < LANES; l++)
         send_request(REQ_WR_VREG, '0, '0, '0, '0, 5'd5, 3'(l), 48'h8000);
      send_request(REQ_EXEC, F_VMULF, 4'd0, 5'd5, 5'd5, 5'd6, 3'd0, '0);
      send_request(REQ_EXEC, F_VMACF, 4'd0, 5'd5, 5'd5, 5'd6, 3'd0, '0);
      for (int k = 0; k < 16; k++) begin
         f = (k < 10) ? ((k == 0) ? F_VMULF : (k <= 5) ? 6'(F_VMUDL + k - 1)
                                                      : 6'(F_VMADL + k - 6))
                      : 6'(6'h30 + k);
         send_request(REQ_EXEC, f, 4'(k), 5'(k % 4), 5'((k + 1) % 4), 5'(6 + k % 3), 3'd0, '0);
      end
      for (int k = 5; k < 8; k++)
         send_request(3'(k), 6'h3F, 4'hF, 5'd31, 5'd31, 5'd31, 3'd7, 48'hFFFF_FFFF_FFFF);
      for (int l = 0; l < LANES; l++) send_request(REQ_RD_ACC, '0, '0, '0, '0, '0, 3'(l), '0);
   endtask

   task automatic test_random_traffic(input int count);
      logic [2:0] kind;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) wait_drained();
         case ($urandom_range(0, 19))
            0, 1, 2: kind = REQ_WR_VREG;
            3, 4: kind = REQ_RD_VREG;
            5: kind = REQ_WR_ACC;
            6, 7: kind = REQ_RD_ACC;
            8: kind = 3'($urandom_range(5, 7));
            default: kind = REQ_EXEC;
         endcase
         if (kind == REQ_EXEC) send_random_op(n % 4 != 0);
         else send_request(kind, 6'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                           (n % 4 != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31)),
                           3'($urandom), pick_value());
      end
   endtask

   always @(posedge clock) begin
      vmac_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[47:0] !== want.read_value)
                  report_mismatch($sformatf("read_value %h, want %h", rsp_tdata[47:0],
                                            want.read_value));
               if (rsp_tdata[APPLIED_BIT] !== want.op_applied)
                  report_mismatch($sformatf("op_applied %b, want %b",
                                            rsp_tdata[APPLIED_BIT], want.op_applied));
            end
         end
         // draw a random stall on ready after each accepted item
         if (rsp_tvalid && rsp_tready)
            rsp_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
         else if (rsp_wait != 0)
            rsp_wait = rsp_wait - 1;
         rsp_tready <= (rsp_wait == 0);
      end
   end

   initial begin
      #20ms;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      fail_count   = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      for (int r = 0; r < NREGS; r++)
         for (int l = 0; l < LANES; l++) model_vreg[r][l] = '0;
      for (int l = 0; l < LANES; l++) begin
         model_lo[l] = '0;
         model_md[l] = '0;
         model_hi[l] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_and_read();
      test_directed_ops();
      test_random_traffic(950);
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
